@@ hdl/assert_macros.svh @@
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under an active-low reset
`define HTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("port check failed");

// next-cycle implication under an active-low reset
`define HTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

@@ hdl/hts_pkg.sv @@
`default_nettype none

package hts_pkg;

    localparam int GRID_CELLS = 20;
    localparam int FRAC_BITS  = 8;
    localparam int HW         = 16;
    localparam int COORD_W    = 5;

    localparam int PTS        = GRID_CELLS + 1;
    localparam int HALF_CELLS = GRID_CELLS / 2;
    localparam int CELL_WORLD = 5;
    localparam int CELL_RAW   = CELL_WORLD * (2 ** FRAC_BITS);
    localparam int CELL_OFF   = HALF_CELLS * CELL_RAW;
    localparam int GRID_RAW   = GRID_CELLS * CELL_RAW;
    localparam int POS_W      = $clog2(GRID_RAW + 2 ** (HW - 1) + 1) + 1;
    localparam int IDX_W      = $clog2(PTS);

    // cell index from whole world units by reciprocal multiply
    localparam int T_W        = $clog2(GRID_CELLS * CELL_WORLD);
    localparam int DIV5_SH    = 10;
    localparam int DIV5_M     = (2 ** DIV5_SH) / CELL_WORLD + 1;
    localparam int PT_W       = T_W + $clog2(DIV5_M + 1);
    localparam int REM_W      = $clog2(CELL_WORLD);
    localparam int W_W        = REM_W + FRAC_BITS;

    // four banks by column and row parity
    localparam int NBANKS     = 4;
    localparam int BANK_SEL_W = 2;
    localparam int BANK_SIDE  = (PTS + 1) / 2;
    localparam int BANK_DEPTH = BANK_SIDE * BANK_SIDE;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    // input beat layout
    localparam int COL_LSB    = 0;
    localparam int ROW_LSB    = COL_LSB + COORD_W;
    localparam int HVAL_LSB   = ROW_LSB + COORD_W;
    localparam int QX_LSB     = HVAL_LSB + HW;
    localparam int QZ_LSB     = QX_LSB + HW;
    localparam int IN_BITS    = QZ_LSB + HW;
    localparam int S_DATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int M_USER_W   = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic           valid;
        logic           oor;
        logic           upper;
        logic           par_x;
        logic           par_z;
        logic [W_W-1:0] dx;
        logic [W_W-1:0] dz;
    } hts_meta_t;

    typedef logic [NBANKS-1:0][HW-1:0] height_quad_t;

    function automatic logic [BANK_AW-1:0] bank_addr(
        input logic [IDX_W-2:0] hc,
        input logic [IDX_W-2:0] hr
    );
        return BANK_AW'(hc * BANK_SIDE) + BANK_AW'(hr);
    endfunction

endpackage

`default_nettype wire

@@ hdl/hts_height_mem.sv @@
`default_nettype none

module hts_height_mem
    import hts_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     adv,
    input  wire logic                     in_beat,
    input  wire logic                     op,
    input  wire logic [COORD_W-1:0]       grid_col,
    input  wire logic [COORD_W-1:0]       grid_row,
    input  wire logic [HW-1:0]            height_value,
    input  wire logic signed [HW-1:0]     query_x,
    input  wire logic signed [HW-1:0]     query_z,
    output hts_meta_t                     meta,
    output height_quad_t                  heights
);

    logic signed [POS_W-1:0]  pos_u;
    logic signed [POS_W-1:0]  pos_v;
    logic                     in_range;
    logic [T_W-1:0]           cell_tx;
    logic [T_W-1:0]           cell_tz;
    logic [PT_W-1:0]          prod_x;
    logic [PT_W-1:0]          prod_z;
    logic [IDX_W-1:0]         cx;
    logic [IDX_W-1:0]         cz;
    logic [REM_W-1:0]         rem_x;
    logic [REM_W-1:0]         rem_z;
    logic [W_W-1:0]           dx;
    logic [W_W-1:0]           dz;
    logic                     upper;
    logic [BANK_SEL_W-1:0]    bsel;
    logic [IDX_W-1:0]         col_sel;
    logic [IDX_W-1:0]         row_sel;
    logic [BANK_AW-1:0]       rd_addr [NBANKS];
    logic                     rd_en;
    logic [IDX_W-1:0]         col_w;
    logic [IDX_W-1:0]         row_w;
    logic                     wr_en;
    logic [BANK_SEL_W-1:0]    wr_bank;
    logic [BANK_AW-1:0]       wr_addr;
    logic [HW-1:0]            rd_data_reg [NBANKS];
    hts_meta_t                meta_reg;
    hts_meta_t                meta_next;

    always_comb
    begin
        pos_u    = POS_W'(query_x) + POS_W'(CELL_OFF);
        pos_v    = POS_W'(CELL_OFF) - POS_W'(query_z);
        in_range = !pos_u[POS_W-1] && !pos_v[POS_W-1]
                   && (pos_u < POS_W'(GRID_RAW)) && (pos_v < POS_W'(GRID_RAW));

        cell_tx = pos_u[FRAC_BITS +: T_W];
        cell_tz = pos_v[FRAC_BITS +: T_W];
        prod_x  = PT_W'(cell_tx) * PT_W'(DIV5_M);
        prod_z  = PT_W'(cell_tz) * PT_W'(DIV5_M);
        cx      = prod_x[DIV5_SH +: IDX_W];
        cz      = prod_z[DIV5_SH +: IDX_W];
        rem_x   = REM_W'(cell_tx - T_W'(cx) * T_W'(CELL_WORLD));
        rem_z   = REM_W'(cell_tz - T_W'(cz) * T_W'(CELL_WORLD));
        dx      = {rem_x, pos_u[FRAC_BITS-1:0]};
        dz      = {rem_z, pos_v[FRAC_BITS-1:0]};
        upper   = ((W_W+1)'(dx) + (W_W+1)'(dz)) < (W_W+1)'(CELL_RAW);

        // each bank serves the one corner whose parity it holds
        bsel    = '0;
        col_sel = '0;
        row_sel = '0;
        for (int b = 0; b < NBANKS; b++)
        begin
            bsel       = BANK_SEL_W'(b);
            col_sel    = cx + IDX_W'(cx[0] ^ bsel[1]);
            row_sel    = cz + IDX_W'(cz[0] ^ bsel[0]);
            rd_addr[b] = bank_addr(col_sel[IDX_W-1:1], row_sel[IDX_W-1:1]);
        end
        rd_en = in_beat && (op == OP_QUERY);

        col_w   = IDX_W'(grid_col);
        row_w   = IDX_W'(grid_row);
        wr_en   = in_beat && (op == OP_WRITE)
                  && (32'(grid_col) <= GRID_CELLS) && (32'(grid_row) <= GRID_CELLS);
        wr_bank = {col_w[0], row_w[0]};
        wr_addr = bank_addr(col_w[IDX_W-1:1], row_w[IDX_W-1:1]);

        meta_next.valid = rd_en;
        meta_next.oor   = !in_range;
        meta_next.upper = upper;
        meta_next.par_x = cx[0];
        meta_next.par_z = cz[0];
        meta_next.dx    = dx;
        meta_next.dz    = dz;
    end

    for (genvar b = 0; b < NBANKS; b++)
    begin : g_bank
        logic [HW-1:0] bank_mem [BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_bank == BANK_SEL_W'(b)))
            begin
                bank_mem[wr_addr] <= height_value;
            end
            if (rd_en)
            begin
                rd_data_reg[b] <= bank_mem[rd_addr[b]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_reg <= '0;
        end
        else if (adv)
        begin
            meta_reg <= meta_next;
        end
    end

    always_comb
    begin
        for (int b = 0; b < NBANKS; b++)
        begin
            heights[b] = rd_data_reg[b];
        end
    end

    assign meta = meta_reg;

endmodule

`default_nettype wire

@@ hdl/hts_interp.sv @@
`default_nettype none

module hts_interp
    import hts_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire hts_meta_t          meta,
    input  wire height_quad_t       heights,
    output logic                    res_valid,
    output logic [HW-1:0]           height_out,
    output logic                    out_of_range,
    output logic                    upper_left_tri
);

    localparam int PROD_W    = HW + W_W + 2;
    localparam int SUM_W     = PROD_W + 1;
    localparam int ROUND_ADD = CELL_RAW / 2;
    localparam int CLAMP     = CELL_WORLD * (2 ** HW);
    localparam int N_W       = $clog2(2 * CLAMP);
    localparam int DIV_SH    = N_W + 2;
    localparam int DIV_M     = (2 ** DIV_SH) / CELL_WORLD + 1;
    localparam int M_W       = $clog2(DIV_M + 1);
    localparam int Q_W       = N_W - 2;
    localparam int H4_W      = Q_W + 1;
    localparam int Q_OFF     = 2 ** HW;
    localparam int HMAX      = 2 ** (HW - 1) - 1;
    localparam int HMIN      = -(2 ** (HW - 1));

    typedef struct packed {
        logic                     valid;
        logic                     oor;
        logic                     upper;
        logic signed [HW-1:0]     base;
        logic signed [PROD_W-1:0] p1;
        logic signed [PROD_W-1:0] p2;
    } s1_t;

    typedef struct packed {
        logic                 valid;
        logic                 oor;
        logic                 upper;
        logic signed [HW-1:0] base;
        logic [N_W-1:0]       n;
    } s2_t;

    typedef struct packed {
        logic                 valid;
        logic                 oor;
        logic                 upper;
        logic signed [HW-1:0] base;
        logic [Q_W-1:0]       q;
    } s3_t;

    typedef struct packed {
        logic          valid;
        logic [HW-1:0] height;
        logic          oor;
        logic          upper;
    } res_t;

    logic signed [HW-1:0]    h00;
    logic signed [HW-1:0]    h10;
    logic signed [HW-1:0]    h01;
    logic signed [HW-1:0]    h11;
    logic signed [HW-1:0]    hb;
    logic signed [HW-1:0]    ha;
    logic signed [HW-1:0]    hc;
    logic [W_W-1:0]          w1;
    logic [W_W-1:0]          w2;
    logic signed [HW:0]      d1;
    logic signed [HW:0]      d2;
    logic signed [SUM_W-1:0] num;
    logic signed [SUM_W-1:0] biased;
    logic signed [SUM_W-1:0] scaled;
    logic signed [SUM_W-1:0] clamped;
    logic [N_W+M_W-1:0]      qprod;
    logic signed [H4_W-1:0]  hsum;
    logic signed [HW-1:0]    hsat;

    s1_t  s1_reg;
    s1_t  s1_next;
    s2_t  s2_reg;
    s2_t  s2_next;
    s3_t  s3_reg;
    s3_t  s3_next;
    res_t res_reg;
    res_t res_next;

    // corner heights and the chosen triangle's plane terms
    always_comb
    begin
        h00 = $signed(heights[{meta.par_x, meta.par_z}]);
        h10 = $signed(heights[{~meta.par_x, meta.par_z}]);
        h01 = $signed(heights[{meta.par_x, ~meta.par_z}]);
        h11 = $signed(heights[{~meta.par_x, ~meta.par_z}]);
        if (meta.upper)
        begin
            hb = h00;
            ha = h10;
            hc = h01;
            w1 = meta.dx;
            w2 = meta.dz;
        end
        else
        begin
            hb = h11;
            ha = h01;
            hc = h10;
            w1 = W_W'(CELL_RAW) - meta.dx;
            w2 = W_W'(CELL_RAW) - meta.dz;
        end
        d1 = (HW+1)'(ha) - (HW+1)'(hb);
        d2 = (HW+1)'(hc) - (HW+1)'(hb);

        s1_next.valid = meta.valid;
        s1_next.oor   = meta.oor;
        s1_next.upper = meta.upper;
        s1_next.base  = hb;
        s1_next.p1    = PROD_W'(d1) * PROD_W'($signed({1'b0, w1}));
        s1_next.p2    = PROD_W'(d2) * PROD_W'($signed({1'b0, w2}));
    end

    // round to nearest, pre-scale by the fraction bits, clamp, and offset to unsigned
    always_comb
    begin
        num    = SUM_W'(s1_reg.p1) + SUM_W'(s1_reg.p2);
        biased = num + SUM_W'(ROUND_ADD);
        scaled = biased >>> FRAC_BITS;
        priority if (scaled < -SUM_W'(CLAMP))
        begin
            clamped = -SUM_W'(CLAMP);
        end
        else if (scaled > SUM_W'(CLAMP - 1))
        begin
            clamped = SUM_W'(CLAMP - 1);
        end
        else
        begin
            clamped = scaled;
        end

        s2_next.valid = s1_reg.valid;
        s2_next.oor   = s1_reg.oor;
        s2_next.upper = s1_reg.upper;
        s2_next.base  = s1_reg.base;
        s2_next.n     = N_W'(clamped + SUM_W'(CLAMP));
    end

    // divide by the whole cell size through a reciprocal multiply
    always_comb
    begin
        qprod         = (N_W+M_W)'(s2_reg.n) * (N_W+M_W)'(DIV_M);
        s3_next.valid = s2_reg.valid;
        s3_next.oor   = s2_reg.oor;
        s3_next.upper = s2_reg.upper;
        s3_next.base  = s2_reg.base;
        s3_next.q     = qprod[DIV_SH +: Q_W];
    end

    always_comb
    begin
        hsum = H4_W'(s3_reg.base) + $signed({1'b0, s3_reg.q}) - H4_W'(Q_OFF);
        priority if (hsum > H4_W'(HMAX))
        begin
            hsat = HW'(HMAX);
        end
        else if (hsum < H4_W'(HMIN))
        begin
            hsat = HW'(HMIN);
        end
        else
        begin
            hsat = HW'(hsum);
        end

        res_next.valid  = s3_reg.valid;
        res_next.oor    = s3_reg.oor;
        res_next.height = s3_reg.oor ? '0 : hsat;
        res_next.upper  = s3_reg.upper && !s3_reg.oor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            s3_reg  <= '0;
            res_reg <= '0;
        end
        else if (adv)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            res_reg <= res_next;
        end
    end

    assign res_valid      = res_reg.valid;
    assign height_out     = res_reg.height;
    assign out_of_range   = res_reg.oor;
    assign upper_left_tri = res_reg.upper;

endmodule

`default_nettype wire

@@ hdl/heightfield_triangle_sample.sv @@
// Terrain height sampler over a 21 x 21 grid of Q8.8 heights, cell size 5, grid centered on
// the origin with world z running against the row index. A write beat (tuser op = 0) stores
// one grid height; a query beat (op = 1) returns one result beat with the height of the
// chosen triangle's plane at (x, z), rounded to nearest and saturated, or out_of_range set
// with height 0. Writes return nothing. One beat of either kind is taken every cycle while the
// output is not stalled; a query result passes registered through the store read, the plane
// products, the rounding, the reciprocal divide and the final saturation. Heights sit in four
// single-read-port banks split by column and row parity, so the four corners of a cell come
// out in one read; a write is visible to a query in the next cycle. Store contents are undefined
// after reset until written, and a query that touches an unwritten point returns
// an undefined height.
`default_nettype none

module heightfield_triangle_sample
    import hts_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // grid_col, grid_row, height_value, query_x, query_z
    input  wire logic [0:0]            s_tuser,   // op
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [HW-1:0]              m_tdata,   // height_out
    output logic [M_USER_W-1:0]        m_tuser    // out_of_range, upper_left_tri
);

    logic         adv;
    logic         in_beat;
    hts_meta_t    meta;
    height_quad_t heights;
    logic         res_valid;
    logic         out_of_range;
    logic         upper_left_tri;

    assign adv      = !res_valid || m_tready;
    assign s_tready = adv;
    assign in_beat  = s_tvalid && adv;

    hts_height_mem u_mem (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_beat      (in_beat),
        .op           (s_tuser[0]),
        .grid_col     (s_tdata[COL_LSB +: COORD_W]),
        .grid_row     (s_tdata[ROW_LSB +: COORD_W]),
        .height_value (s_tdata[HVAL_LSB +: HW]),
        .query_x      ($signed(s_tdata[QX_LSB +: HW])),
        .query_z      ($signed(s_tdata[QZ_LSB +: HW])),
        .meta         (meta),
        .heights      (heights)
    );

    hts_interp u_interp (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .meta           (meta),
        .heights        (heights),
        .res_valid      (res_valid),
        .height_out     (m_tdata),
        .out_of_range   (out_of_range),
        .upper_left_tri (upper_left_tri)
    );

    assign m_tvalid = res_valid;
    assign m_tuser  = {upper_left_tri, out_of_range};

endmodule

`default_nettype wire

@@ hdl/hts_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module hts_checker
    import hts_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [HW-1:0]       m_tdata,
    input wire logic [M_USER_W-1:0] m_tuser
);

    `HTS_ASSERT_NOW(a_oor_zero, clk, rst_n, m_tvalid && m_tuser[0], (m_tdata == '0) && !m_tuser[1])
    `HTS_ASSERT_NOW(a_ready_free, clk, rst_n, !m_tvalid || m_tready, s_tready)
    `HTS_ASSERT_NOW(a_stall_blocks, clk, rst_n, m_tvalid && !m_tready, !s_tready)
    `HTS_ASSERT_NOW(a_empty_after_reset, clk, rst_n, !$past(rst_n), !m_tvalid)
    `HTS_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind heightfield_triangle_sample hts_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/heightfield_triangle_sample_tb.sv @@
`default_nettype none

module heightfield_triangle_sample_tb;
    import hts_pkg::*;

    typedef struct packed {
        logic                op;
        logic [S_DATA_W-1:0] data;
    } beat_t;

    typedef struct packed {
        logic [HW-1:0] height;
        logic          oor;
        logic          upper;
    } sample_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [0:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [HW-1:0]       m_tdata;
    logic [M_USER_W-1:0] m_tuser;

    heightfield_triangle_sample dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    beat_t   pending_beats[$];
    sample_t expected_samples[$];
    logic signed [HW-1:0] grid_h [0:PTS*PTS-1];

    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    stall_req     = 0;
    int    stall_ack     = 0;
    int    stall_left    = 0;
    int    issued_cnt    = 0;
    int    accepted_cnt  = 0;
    int    mismatch_cnt  = 0;
    int    results_checked = 0;
    int    n_loads = 0;
    int    n_dropped = 0;
    int    n_upper = 0;
    int    n_lower = 0;
    int    n_outside = 0;
    logic  in_taken = 1'b0;
    beat_t next_beat;
    sample_t got_sample;
    sample_t want_sample;

    function automatic longint floor_q(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint round_q(longint num, longint den);
        return floor_q(2 * num + den, 2 * den);
    endfunction

    function automatic sample_t sample_terrain(logic signed [HW-1:0] qx,
                                               logic signed [HW-1:0] qz);
        longint u, v, cx, cz, dx, dz, h00, h10, h01, h11, h;
        sample_t r;
        r = '0;
        u = longint'(qx) + CELL_OFF;
        v = -longint'(qz) + CELL_OFF;
        cx = floor_q(u, CELL_RAW);
        cz = floor_q(v, CELL_RAW);
        if (cx < 0 || cx >= GRID_CELLS || cz < 0 || cz >= GRID_CELLS)
        begin
            r.oor = 1'b1;
            return r;
        end
        dx = u - cx * CELL_RAW;
        dz = v - cz * CELL_RAW;
        h00 = grid_h[cx * PTS + cz];
        h10 = grid_h[(cx + 1) * PTS + cz];
        h01 = grid_h[cx * PTS + cz + 1];
        h11 = grid_h[(cx + 1) * PTS + cz + 1];
        if (dx + dz < CELL_RAW)
        begin
            r.upper = 1'b1;
            h = h00 + round_q((h10 - h00) * dx + (h01 - h00) * dz, CELL_RAW);
        end
        else
        begin
            h = h11 + round_q((h01 - h11) * (CELL_RAW - dx) +
                              (h10 - h11) * (CELL_RAW - dz), CELL_RAW);
        end
        if (h > 32767)
            h = 32767;
        if (h < -32768)
            h = -32768;
        r.height = h[HW-1:0];
        return r;
    endfunction

    function automatic beat_t make_beat(logic op, int col, int row, int hv,
                                        int qx, int qz);
        beat_t b;
        b.op = op;
        b.data = '0;
        b.data[COL_LSB +: COORD_W] = COORD_W'(col);
        b.data[ROW_LSB +: COORD_W] = COORD_W'(row);
        b.data[HVAL_LSB +: HW]     = HW'(hv);
        b.data[QX_LSB +: HW]       = HW'(qx);
        b.data[QZ_LSB +: HW]       = HW'(qz);
        return b;
    endfunction

    task automatic push_load(int col, int row, int hv);
        pending_beats.push_back(make_beat(OP_WRITE, col, row, hv,
                                          $urandom_range(0, 65535),
                                          $urandom_range(0, 65535)));
        issued_cnt++;
    endtask

    task automatic push_sample(int qx, int qz);
        pending_beats.push_back(make_beat(OP_QUERY, $urandom_range(0, 31),
                                          $urandom_range(0, 31),
                                          $urandom_range(0, 65535), qx, qz));
        issued_cnt++;
    endtask

    function automatic int pick_height();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return 32767;
            1: return -32768;
            2: return 0;
            3: return $urandom_range(0, 511) - 256;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic push_mixed(int n);
        int sel;
        repeat (n)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 27)
                push_load($urandom_range(0, GRID_CELLS), $urandom_range(0, GRID_CELLS),
                          pick_height());
            else if (sel < 30)
                push_load($urandom_range(0, 31), $urandom_range(0, 31), pick_height());
            else if (sel < 85)
                push_sample($urandom_range(0, GRID_RAW - 1) - CELL_OFF,
                            CELL_OFF - $urandom_range(0, GRID_RAW - 1));
            else
                push_sample($urandom_range(0, 65535), $urandom_range(0, 65535));
        end
    endtask

    task automatic wait_drain();
        while (accepted_cnt != issued_cnt || expected_samples.size() != 0)
            @(posedge clk);
    endtask

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_beat = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_beat.data;
                s_tuser  <= next_beat.op;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_req != stall_ack)
        begin
            m_tready   <= 1'b0;
            stall_left <= 300;
            stall_ack  <= stall_req;
        end
        else
        begin
            m_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor and predictor
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_sample.height = m_tdata;
            got_sample.oor    = m_tuser[0];
            got_sample.upper  = m_tuser[1];
            if (expected_samples.size() == 0)
            begin
                $error("result beat with nothing expected: height_out %0d", $signed(m_tdata));
                mismatch_cnt++;
            end
            else
            begin
                want_sample = expected_samples.pop_front();
                results_checked++;
                if (got_sample.height !== want_sample.height)
                begin
                    $error("height_out expected %0d got %0d",
                           $signed(want_sample.height), $signed(got_sample.height));
                    mismatch_cnt++;
                end
                if (got_sample.oor !== want_sample.oor)
                begin
                    $error("out_of_range expected %0b got %0b", want_sample.oor, got_sample.oor);
                    mismatch_cnt++;
                end
                if (got_sample.upper !== want_sample.upper)
                begin
                    $error("upper_left_tri expected %0b got %0b",
                           want_sample.upper, got_sample.upper);
                    mismatch_cnt++;
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            accepted_cnt <= accepted_cnt + 1;
            if (s_tuser[0] == OP_WRITE)
            begin
                if (s_tdata[COL_LSB +: COORD_W] <= GRID_CELLS &&
                    s_tdata[ROW_LSB +: COORD_W] <= GRID_CELLS)
                begin
                    grid_h[s_tdata[COL_LSB +: COORD_W] * PTS + s_tdata[ROW_LSB +: COORD_W]] =
                        s_tdata[HVAL_LSB +: HW];
                    n_loads++;
                end
                else
                begin
                    n_dropped++;
                end
            end
            else
            begin
                want_sample = sample_terrain(s_tdata[QX_LSB +: HW], s_tdata[QZ_LSB +: HW]);
                expected_samples.push_back(want_sample);
                if (want_sample.oor)
                    n_outside++;
                else if (want_sample.upper)
                    n_upper++;
                else
                    n_lower++;
            end
        end
    end

    initial
    begin
        int order [PTS*PTS];
        int j, t;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 79;

        // corners of the first and last cells, extreme heights
        push_load(0, 0, 32767);
        push_load(1, 0, -32768);
        push_load(0, 1, -32768);
        push_load(1, 1, 32767);
        push_load(19, 19, -1);
        push_load(20, 19, 32767);
        push_load(19, 20, -32768);
        push_load(20, 20, 0);
        // off-grid loads are dropped
        push_load(31, 5, 1234);
        push_load(3, 31, -1234);
        push_load(21, 21, 77);
        // corner point, triangle split edges, far corner
        push_sample(-12800, 12800);
        push_sample(-12800 + 639, 12800 - 640);
        push_sample(-12800 + 640, 12800 - 640);
        push_sample(-11521, 11521);
        push_sample(12799, -12799);
        push_sample(11520, -11520);
        // just outside each edge and the extremes
        push_sample(12800, 0);
        push_sample(-12801, 0);
        push_sample(0, -12800);
        push_sample(0, 12801);
        push_sample(32767, -32768);
        push_sample(-32768, 32767);
        wait_drain();

        // load every grid point in shuffled order
        for (int i = 0; i < PTS * PTS; i++)
            order[i] = i;
        for (int i = PTS * PTS - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < PTS * PTS; i++)
            push_load(order[i] / PTS, order[i] % PTS, pick_height());
        push_mixed(60);
        wait_drain();

        send_idle_pct = 79;
        recv_idle_pct = 17;
        push_mixed(190);
        wait_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_mixed(190);
        @(posedge clk);
        stall_req = stall_req + 1;
        wait_drain();

        repeat (20) @(posedge clk);
        $display("loaded %0d heights, %0d dropped; sampled %0d upper, %0d lower, %0d outside",
                 n_loads, n_dropped, n_upper, n_lower, n_outside);
        $display("%0d result beats checked under three idle mixes and a long output stall",
                 results_checked);
        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
